@@ design/pfb_pkg.sv @@
// ----------------------------------------------------------------------------
// pfb_pkg: shared types and codes of the page framebuffer bar renderer
// Command and status codes, and the control and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfb_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_BAR   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] ST_DONE        = 2'd0;
  localparam logic [1:0] ST_BAR_IGNORED = 2'd1;
  localparam logic [1:0] ST_READ_RANGE  = 2'd2;

  // Quotient width of the fill divider: a 16-bit value times an 8-bit width.
  localparam int DIV_QW = 24;
  localparam int DIV_DW = 16;

  typedef struct packed {
    logic       latch;
    logic       clr_step;
    logic       div_load;
    logic       rd_pix;
    logic       wr_pix;
    logic       rd_byte;
    logic       adv;
    logic       finish;
    logic       fin_data;
    logic [1:0] fin_status;
  } pfb_ctl_t;

  typedef struct packed {
    logic clr_last;
    logic div_busy;
    logic on_panel;
    logic last_pix;
    logic max_nonpos;
    logic size_zero;
    logic idx_out;
  } pfb_sts_t;

endpackage

@@ design/pfb_div.sv @@
// ----------------------------------------------------------------------------
// pfb_div: restoring divider for the bar fill width
// One quotient bit per cycle; the quotient register holds its value after
// the last step until the next load.
// ----------------------------------------------------------------------------
module pfb_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [pfb_pkg::DIV_QW-1:0]  dividend,
  input  logic [pfb_pkg::DIV_DW-1:0]  divisor,
  output logic                        busy,
  output logic [pfb_pkg::DIV_QW-1:0]  quotient
);
  import pfb_pkg::*;

  localparam int CNT_W = $clog2(DIV_QW + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_QW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dsr_r, dsr_nxt;
  logic [DIV_DW-1:0] trial;

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    trial   = {rem_r[DIV_DW-2:0], quo_r[DIV_QW-1]};
    if (load) begin
      cnt_nxt = CNT_W'(DIV_QW);
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= dsr_r) begin
        rem_nxt = trial - dsr_r;
        quo_nxt = {quo_r[DIV_QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DIV_QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

@@ design/pfb_dp.sv @@
// ----------------------------------------------------------------------------
// pfb_dp: datapath of the page framebuffer bar renderer
// Holds the frame store, the latched command, the bar walk counters, the
// clear sweep address, the panel size register and the result register.
// ----------------------------------------------------------------------------
module pfb_dp #(
  parameter int PANEL_WIDTH = 128,
  parameter int MAX_PAGES   = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pfb_pkg::pfb_ctl_t   ctl,
  output pfb_pkg::pfb_sts_t   sts,
  input  logic [1:0]          in_cmd,
  input  logic signed [8:0]   in_pos_x,
  input  logic signed [8:0]   in_pos_y,
  input  logic                in_pixel_on,
  input  logic [7:0]          in_bar_width,
  input  logic [7:0]          in_bar_height,
  input  logic signed [15:0]  in_fill_value,
  input  logic signed [15:0]  in_fill_max,
  input  logic [9:0]          in_byte_index,
  input  logic                cfg_valid,
  input  logic                cfg_tall_panel,
  output logic                out_valid,
  output logic [7:0]          out_read_data,
  output logic [1:0]          out_status
);
  import pfb_pkg::*;

  localparam int STORE_SIZE = PANEL_WIDTH * MAX_PAGES;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int COL_W      = $clog2(PANEL_WIDTH);
  localparam int PAGE_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int HALF_PAGES = (MAX_PAGES + 1) / 2;
  localparam int LIM_W      = $clog2(STORE_SIZE + 1);
  localparam int CMP_W      = (LIM_W > 10) ? LIM_W : 10;

  localparam logic signed [10:0] PW_S         = 11'(PANEL_WIDTH);
  localparam logic signed [10:0] ROWS_TALL_S  = 11'(MAX_PAGES * 8);
  localparam logic signed [10:0] ROWS_SHORT_S = 11'(HALF_PAGES * 8);
  localparam logic [LIM_W-1:0]   LIM_TALL     = LIM_W'(STORE_SIZE);
  localparam logic [LIM_W-1:0]   LIM_SHORT    = LIM_W'(PANEL_WIDTH * HALF_PAGES);
  localparam logic [ADDR_W-1:0]  LAST_ADDR    = ADDR_W'(STORE_SIZE - 1);

  // Frame store.
  logic [7:0] mem [STORE_SIZE];
  logic [7:0] mem_q_r;

  logic              tall_r;
  logic [1:0]        cmd_r;
  logic signed [8:0] x_r, y_r;
  logic              on_r;
  logic [7:0]        w_r, h_r;
  logic signed [15:0] val_r, max_r;
  logic [9:0]        idx_r;
  logic [7:0]        col_r, col_nxt;
  logic [7:0]        row_r, row_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              out_valid_r;
  logic [7:0]        out_data_r;
  logic [1:0]        out_status_r;

  logic signed [10:0] px, py, rows_s;
  logic [PAGE_W-1:0]  page;
  logic [COL_W-1:0]   colv;
  logic [ADDR_W-1:0]  tgt_addr, idx_addr, mem_wa, mem_ra;
  logic [7:0]         mem_wd, bit_mask;
  logic               mem_we, mem_re;
  logic               col_last, row_last, is_fill, is_border, pix_val;
  logic signed [24:0] prod;
  logic [DIV_QW-1:0]  dividend, quotient;
  logic [7:0]         fill;
  logic               div_busy;
  logic [LIM_W-1:0]   limit;

  pfb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (ctl.div_load),
    .dividend (dividend),
    .divisor  (max_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Fill width: value times width over max, nonpositive products fill nothing.
  assign prod     = val_r * $signed({1'b0, w_r});
  assign dividend = prod[24] ? '0 : prod[DIV_QW-1:0];
  assign fill     = (quotient > DIV_QW'(w_r)) ? w_r : quotient[7:0];

  // Current target pixel: corner plus walk offsets (offsets stay zero for a pixel).
  assign px     = $signed({{2{x_r[8]}}, x_r}) + $signed({3'b000, col_r});
  assign py     = $signed({{2{y_r[8]}}, y_r}) + $signed({3'b000, row_r});
  assign rows_s = tall_r ? ROWS_TALL_S : ROWS_SHORT_S;
  assign page   = py[3+PAGE_W-1:3];
  assign colv   = px[COL_W-1:0];
  assign tgt_addr = ADDR_W'(ADDR_W'(page) * ADDR_W'(PANEL_WIDTH)) + ADDR_W'(colv);
  assign idx_addr = ADDR_W'(idx_r);
  assign limit    = tall_r ? LIM_TALL : LIM_SHORT;

  assign col_last  = (col_r == w_r - 8'd1);
  assign row_last  = (row_r == h_r - 8'd1);
  assign is_fill   = (col_r < fill);
  assign is_border = (row_r == 8'd0) || row_last || (col_r == 8'd0) || col_last;
  assign pix_val   = (cmd_r == CMD_PIXEL) ? on_r : (is_fill || is_border);
  assign bit_mask  = 8'd1 << py[2:0];

  assign mem_we = ctl.clr_step | ctl.wr_pix;
  assign mem_re = ctl.rd_pix | ctl.rd_byte;
  assign mem_wa = ctl.clr_step ? clr_addr_r : tgt_addr;
  assign mem_ra = ctl.rd_byte ? idx_addr : tgt_addr;
  assign mem_wd = ctl.clr_step ? 8'd0 :
                  (pix_val ? (mem_q_r | bit_mask) : (mem_q_r & ~bit_mask));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_ra];
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (ctl.latch) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (ctl.adv) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_r + 8'd1;
      end else begin
        col_nxt = col_r + 8'd1;
      end
    end
    clr_addr_nxt = clr_addr_r;
    if (ctl.clr_step) begin
      clr_addr_nxt = (clr_addr_r == LAST_ADDR) ? '0 : clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tall_r      <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tall_r <= cfg_tall_panel;
      end
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= ctl.finish;
    end
    col_r <= col_nxt;
    row_r <= row_nxt;
    if (ctl.latch) begin
      cmd_r <= in_cmd;
      x_r   <= in_pos_x;
      y_r   <= in_pos_y;
      on_r  <= in_pixel_on;
      w_r   <= in_bar_width;
      h_r   <= in_bar_height;
      val_r <= in_fill_value;
      max_r <= in_fill_max;
      idx_r <= in_byte_index;
    end
    if (ctl.finish) begin
      out_data_r   <= ctl.fin_data ? mem_q_r : 8'd0;
      out_status_r <= ctl.fin_status;
    end
  end

  // The active limit never exceeds the store size, so one compare covers both.
  always_comb begin
    sts.clr_last   = (clr_addr_r == LAST_ADDR);
    sts.div_busy   = div_busy;
    sts.on_panel   = (px >= 0) && (px < PW_S) && (py >= 0) && (py < rows_s);
    sts.last_pix   = (cmd_r == CMD_PIXEL) || (col_last && row_last);
    sts.max_nonpos = (max_r <= 16'sd0);
    sts.size_zero  = (w_r == 8'd0) || (h_r == 8'd0);
    sts.idx_out    = (CMP_W'(idx_r) >= CMP_W'(limit));
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_status    = out_status_r;

endmodule

@@ design/pfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfb_ctrl: command sequencer of the page framebuffer bar renderer
// Runs the clearing pass after reset and steps each command through the
// datapath: clear sweep, bar setup and divide, pixel walk, byte read.
// ----------------------------------------------------------------------------
module pfb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_cmd,
  output logic               busy,
  output pfb_pkg::pfb_ctl_t  ctl,
  input  pfb_pkg::pfb_sts_t  sts
);
  import pfb_pkg::*;

  localparam logic [3:0] S_RST_CLR = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_CLEAR   = 4'd2;
  localparam logic [3:0] S_BAR_CHK = 4'd3;
  localparam logic [3:0] S_DIV     = 4'd4;
  localparam logic [3:0] S_PIX_RD  = 4'd5;
  localparam logic [3:0] S_PIX_WR  = 4'd6;
  localparam logic [3:0] S_READ    = 4'd7;
  localparam logic [3:0] S_RD_DATA = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_RST_CLR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          unique case (in_cmd)
            CMD_CLEAR: state_nxt = S_CLEAR;
            CMD_PIXEL: state_nxt = S_PIX_RD;
            CMD_BAR:   state_nxt = S_BAR_CHK;
            default:   state_nxt = S_READ;
          endcase
        end
      end
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_DONE;
          state_nxt      = S_IDLE;
        end
      end
      S_BAR_CHK: begin
        if (sts.max_nonpos) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_BAR_IGNORED;
          state_nxt      = S_IDLE;
        end else if (sts.size_zero) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_DONE;
          state_nxt      = S_IDLE;
        end else begin
          ctl.div_load = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_PIX_RD;
        end
      end
      S_PIX_RD: begin
        // Pixels off the panel are stepped over without a store access.
        if (sts.on_panel) begin
          ctl.rd_pix = 1'b1;
          state_nxt  = S_PIX_WR;
        end else begin
          ctl.adv = 1'b1;
          if (sts.last_pix) begin
            ctl.finish     = 1'b1;
            ctl.fin_status = ST_DONE;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_PIX_WR: begin
        ctl.wr_pix = 1'b1;
        ctl.adv    = 1'b1;
        if (sts.last_pix) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_DONE;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_PIX_RD;
        end
      end
      S_READ: begin
        if (sts.idx_out) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_READ_RANGE;
          state_nxt      = S_IDLE;
        end else begin
          ctl.rd_byte = 1'b1;
          state_nxt   = S_RD_DATA;
        end
      end
      S_RD_DATA: begin
        ctl.finish     = 1'b1;
        ctl.fin_data   = 1'b1;
        ctl.fin_status = ST_DONE;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ design/page_framebuffer_bar_renderer.sv @@
// ----------------------------------------------------------------------------
// page_framebuffer_bar_renderer: page-organized monochrome frame store
// Clear, pixel, progress bar and byte read commands on a one-bit-per-pixel
// store of PANEL_WIDTH columns by MAX_PAGES pages of 8 rows.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown for one cycle with out_valid high, and the
// receiver cannot stall it. A read fetches the byte and then returns it (it
// finishes at once when the index is out of range); a pixel is read and then
// written back (skipped when off the panel); a clear sweeps every store
// address; a bar finishes at once when ignored or empty, else runs the fill
// divider, one bit a cycle, then reads and writes each on-panel pixel of the
// width*height rectangle and steps over each off-panel one. The result is
// registered and appears in the cycle after the finishing state, when busy
// is already low. After reset busy stays high while the store is cleared.
// Configuration writes are always accepted (cfg_ready is tied high).
module page_framebuffer_bar_renderer #(
  parameter int PANEL_WIDTH = 128,
  parameter int MAX_PAGES   = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [8:0]  in_pos_x,
  input  logic signed [8:0]  in_pos_y,
  input  logic               in_pixel_on,
  input  logic [7:0]         in_bar_width,
  input  logic [7:0]         in_bar_height,
  input  logic signed [15:0] in_fill_value,
  input  logic signed [15:0] in_fill_max,
  input  logic [9:0]         in_byte_index,
  output logic               out_valid,
  output logic [7:0]         out_read_data,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_tall_panel
);
  import pfb_pkg::*;

  pfb_ctl_t ctl;
  pfb_sts_t sts;

  pfb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .busy   (busy),
    .ctl    (ctl),
    .sts    (sts)
  );

  pfb_dp #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .MAX_PAGES   (MAX_PAGES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_cmd         (in_cmd),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pixel_on    (in_pixel_on),
    .in_bar_width   (in_bar_width),
    .in_bar_height  (in_bar_height),
    .in_fill_value  (in_fill_value),
    .in_fill_max    (in_fill_max),
    .in_byte_index  (in_byte_index),
    .cfg_valid      (cfg_valid),
    .cfg_tall_panel (cfg_tall_panel),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_status     (out_status)
  );

  assign cfg_ready = 1'b1;

endmodule

@@ design/pfb_checker.sv @@
// ----------------------------------------------------------------------------
// pfb_checker: port-level checks of the page framebuffer bar renderer
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module pfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [7:0] out_read_data,
  input logic [1:0] out_status
);
  import pfb_pkg::*;

  // Busy is high in the cycle after a command is taken.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low right after a command was taken");

  // Result beats never come back to back.
  a_no_double_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result beats in a row");

  // A result only follows a cycle in which a command was in work.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a command in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_BAR_IGNORED ||
                   out_status == ST_READ_RANGE))
    else $error("undefined status code");

  a_error_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_read_data == 8'd0)
    else $error("nonzero data with an error status");

endmodule

bind page_framebuffer_bar_renderer pfb_checker u_pfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_read_data (out_read_data),
  .out_status    (out_status)
);
